/* hw/rtl/gpf_pkg.sv */
package gpf_pkg;

    localparam int MAX_DIM_DEF       = 256;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int SIZE_W     = 9;
    localparam int OFF_W      = 9;
    localparam int STEP_W     = 32;
    localparam int ADDR_W     = 24;
    localparam int Q15_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Q30 datapath with headroom for CORDIC growth
    localparam int CORDIC_W = 34;
    localparam int RND_W    = CORDIC_W - 14;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_X_SIZE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP_Z = 3'd5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [RND_W-1:0]    Q15_MAX     = 20'sd32767;
    localparam logic signed [RND_W-1:0]    Q15_MIN     = -20'sd32768;
    localparam logic signed [CORDIC_W:0]   Q15_HALF    = 35'sd16384;

    typedef struct packed {
        logic [SIZE_W-1:0] x_size;
        logic [SIZE_W-1:0] y_size;
        logic [SIZE_W-1:0] z_size;
        logic [STEP_W-1:0] phase_step_x;
        logic [STEP_W-1:0] phase_step_y;
        logic [STEP_W-1:0] phase_step_z;
    } gpf_cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [STEP_W-1:0] angle;
        logic              neg;
        logic              oor;
    } gpf_item_t;

    // arctangent of 2^-i in 2^-32 turns, truncated
    function automatic logic [STEP_W-1:0] atan_turn(input int i);
        logic [STEP_W-1:0] a;
        case (i)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051D;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2E;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2F9;
            15: a = 32'h0000517C;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A2F;
            19: a = 32'h00000517;
            20: a = 32'h0000028B;
            21: a = 32'h00000145;
            22: a = 32'h000000A2;
            23: a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

    // round Q30 to Q15, saturate, optional negate with saturation
    function automatic logic [Q15_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v,
                                                 input logic neg);
        logic signed [CORDIC_W:0] s;
        logic signed [RND_W-1:0]  r;
        logic [Q15_W-1:0]         q;
        s = {v[CORDIC_W-1], v} + Q15_HALF;
        r = s[CORDIC_W:15];
        if (r > Q15_MAX) begin
            q = 16'h7FFF;
        end else if (r < Q15_MIN) begin
            q = 16'h8000;
        end else begin
            q = r[Q15_W-1:0];
        end
        if (neg) begin
            if (q == 16'h8000) begin
                q = 16'h7FFF;
            end else begin
                q = Q15_W'(-q);
            end
        end
        return q;
    endfunction

endpackage

/* hw/rtl/grid_phase_factor_generator.sv */
// Channel   Dir  Handshake              Word
// s_*       in   s_valid / s_ready      x, y, z offsets (9-bit signed each)
// m_*       out  m_valid / m_ready      grid address, cos, sin, out-of-range flag
// cfg_*     in   cfg_valid / cfg_ready  register index, write data
//
// One word per cycle sustained while m_ready stays high. With no stall a word passes
// two front stages (wrap/products, address/phase sum), one queue slot, one
// CORDIC stage per rotation and one output register.
// Synchronous active-low reset clears control and loads register reset values.
// The 4-entry queue lets the front keep taking words while the CORDIC pipe stalls.
module grid_phase_factor_generator
    import gpf_pkg::*;
#(
    parameter int MAX_DIM       = MAX_DIM_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OFF_W-1:0]      s_x_offset,
    input  logic [OFF_W-1:0]      s_y_offset,
    input  logic [OFF_W-1:0]      s_z_offset,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ADDR_W-1:0]     m_grid_address,
    output logic [Q15_W-1:0]      m_cos_value,
    output logic [Q15_W-1:0]      m_sin_value,
    output logic                  m_out_of_range
);

    gpf_cfg_t  cfg_reg;
    logic      fq_valid, fq_ready;
    gpf_item_t fq_item;
    logic      qb_valid, qb_ready;
    gpf_item_t qb_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_size       <= SIZE_RESET;
            cfg_reg.y_size       <= SIZE_RESET;
            cfg_reg.z_size       <= SIZE_RESET;
            cfg_reg.phase_step_x <= '0;
            cfg_reg.phase_step_y <= '0;
            cfg_reg.phase_step_z <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_X_SIZE:       cfg_reg.x_size       <= cfg_data[SIZE_W-1:0];
                REG_Y_SIZE:       cfg_reg.y_size       <= cfg_data[SIZE_W-1:0];
                REG_Z_SIZE:       cfg_reg.z_size       <= cfg_data[SIZE_W-1:0];
                REG_PHASE_STEP_X: cfg_reg.phase_step_x <= cfg_data[STEP_W-1:0];
                REG_PHASE_STEP_Y: cfg_reg.phase_step_y <= cfg_data[STEP_W-1:0];
                REG_PHASE_STEP_Z: cfg_reg.phase_step_z <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    gpf_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_x_offset (s_x_offset),
        .s_y_offset (s_y_offset),
        .s_z_offset (s_z_offset),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_item     (fq_item)
    );

    gpf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    gpf_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (qb_valid),
        .q_ready        (qb_ready),
        .q_item         (qb_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_grid_address (m_grid_address),
        .m_cos_value    (m_cos_value),
        .m_sin_value    (m_sin_value),
        .m_out_of_range (m_out_of_range)
    );

endmodule

/* hw/rtl/gpf_front.sv */
module gpf_front
    import gpf_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  gpf_cfg_t          cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OFF_W-1:0]  s_x_offset,
    input  logic [OFF_W-1:0]  s_y_offset,
    input  logic [OFF_W-1:0]  s_z_offset,
    output logic              q_valid,
    input  logic              q_ready,
    output gpf_item_t         q_item
);

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] e;
        if (int'(s) > MAX_DIM) begin
            e = SIZE_W'(MAX_DIM);
        end else begin
            e = s;
        end
        return e;
    endfunction

    function automatic logic [SIZE_W:0] wrap_off(input logic [OFF_W-1:0] off,
                                                 input logic [SIZE_W-1:0] sz);
        logic [SIZE_W:0] w;
        if (off[OFF_W-1]) begin
            w = {off[OFF_W-1], off} + {1'b0, sz};
        end else begin
            w = {1'b0, off};
        end
        return w;
    endfunction

    function automatic logic off_bad(input logic [OFF_W-1:0] off,
                                     input logic [SIZE_W-1:0] sz);
        logic signed [SIZE_W+1:0] o;
        logic signed [SIZE_W+1:0] h;
        o = {{2{off[OFF_W-1]}}, off};
        h = {2'b00, sz >> 1};
        return (o > h) || (o < -h);
    endfunction

    function automatic logic [STEP_W-1:0] phase_part(input logic [OFF_W-1:0] off,
                                                     input logic [STEP_W-1:0] step);
        return STEP_W'({{(STEP_W-OFF_W){off[OFF_W-1]}}, off} * step);
    endfunction

    logic [SIZE_W-1:0] sz_x, sz_y, sz_z;
    logic [SIZE_W:0]   w_x, w_y, w_z;
    logic              en1, en2;

    logic              v1_reg;
    logic [STEP_W-1:0] p_x_reg, p_y_reg, p_z_reg;
    logic [ADDR_W-1:0] wxy_reg;
    logic [SIZE_W:0]   wy_reg, wz_reg;
    logic              oor1_reg;

    logic              v2_reg;
    gpf_item_t         item2_reg;
    gpf_item_t         item2_next;
    logic [STEP_W-1:0] phase_sum;

    assign sz_x = eff_size(cfg.x_size);
    assign sz_y = eff_size(cfg.y_size);
    assign sz_z = eff_size(cfg.z_size);

    assign w_x = wrap_off(s_x_offset, sz_x);
    assign w_y = wrap_off(s_y_offset, sz_y);
    assign w_z = wrap_off(s_z_offset, sz_z);

    assign en2     = !v2_reg || q_ready;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // stage 1: wrap, range check, per-axis products
    always_ff @(posedge aclk) begin
        if (en1 && s_valid) begin
            p_x_reg  <= phase_part(s_x_offset, cfg.phase_step_x);
            p_y_reg  <= phase_part(s_y_offset, cfg.phase_step_y);
            p_z_reg  <= phase_part(s_z_offset, cfg.phase_step_z);
            wxy_reg  <= ADDR_W'({{(ADDR_W-SIZE_W-1){w_x[SIZE_W]}}, w_x}
                                * {{(ADDR_W-SIZE_W){1'b0}}, sz_y});
            wy_reg   <= w_y;
            wz_reg   <= w_z;
            oor1_reg <= off_bad(s_x_offset, sz_x) || off_bad(s_y_offset, sz_y)
                        || off_bad(s_z_offset, sz_z);
        end
    end

    // stage 2: address, phase sum, quadrant fold
    always_comb begin
        phase_sum       = p_x_reg + p_y_reg + p_z_reg;
        item2_next.addr = ADDR_W'((wxy_reg + {{(ADDR_W-SIZE_W-1){wy_reg[SIZE_W]}}, wy_reg})
                                  * {{(ADDR_W-SIZE_W){1'b0}}, sz_z})
                          + {{(ADDR_W-SIZE_W-1){wz_reg[SIZE_W]}}, wz_reg};
        item2_next.neg  = phase_sum[STEP_W-1] ^ phase_sum[STEP_W-2];
        item2_next.angle = item2_next.neg ?
                           {~phase_sum[STEP_W-1], phase_sum[STEP_W-2:0]} : phase_sum;
        item2_next.oor  = oor1_reg;
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            item2_reg <= item2_next;
        end
    end

    assign q_valid = v2_reg;
    assign q_item  = item2_reg;

endmodule

/* hw/rtl/gpf_queue.sv */
module gpf_queue
    import gpf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  gpf_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output gpf_item_t out_item
);

    gpf_item_t              mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push, pop;

    assign in_ready  = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? QUEUE_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QUEUE_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = QUEUE_CNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = QUEUE_CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* hw/rtl/gpf_cordic.sv */
module gpf_cordic
    import gpf_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  gpf_item_t         q_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ADDR_W-1:0] m_grid_address,
    output logic [Q15_W-1:0]  m_cos_value,
    output logic [Q15_W-1:0]  m_sin_value,
    output logic              m_out_of_range
);

    logic signed [CORDIC_W-1:0] x_reg [STAGES];
    logic signed [CORDIC_W-1:0] y_reg [STAGES];
    logic signed [CORDIC_W-1:0] z_reg [STAGES];
    logic [ADDR_W-1:0]          addr_reg [STAGES];
    logic [STAGES-1:0]          neg_reg, oor_reg, v_reg;

    logic signed [CORDIC_W-1:0] x_in [STAGES];
    logic signed [CORDIC_W-1:0] y_in [STAGES];
    logic signed [CORDIC_W-1:0] z_in [STAGES];
    logic signed [CORDIC_W-1:0] x_next [STAGES];
    logic signed [CORDIC_W-1:0] y_next [STAGES];
    logic signed [CORDIC_W-1:0] z_next [STAGES];
    logic [ADDR_W-1:0]          addr_in [STAGES];
    logic [STAGES-1:0]          neg_in, oor_in, v_in;
    logic [STAGES:0]            en;

    logic              m_valid_reg;
    logic [ADDR_W-1:0] m_addr_reg;
    logic [Q15_W-1:0]  m_cos_reg, m_sin_reg;
    logic              m_oor_reg;

    always_comb begin
        en[STAGES] = !m_valid_reg || m_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign q_ready = en[0];

    always_comb begin
        x_in[0]    = CORDIC_GAIN;
        y_in[0]    = '0;
        z_in[0]    = {{(CORDIC_W-STEP_W){q_item.angle[STEP_W-1]}}, q_item.angle};
        addr_in[0] = q_item.addr;
        neg_in[0]  = q_item.neg;
        oor_in[0]  = q_item.oor;
        v_in[0]    = q_valid;
        for (int k = 1; k < STAGES; k++) begin
            x_in[k]    = x_reg[k-1];
            y_in[k]    = y_reg[k-1];
            z_in[k]    = z_reg[k-1];
            addr_in[k] = addr_reg[k-1];
            neg_in[k]  = neg_reg[k-1];
            oor_in[k]  = oor_reg[k-1];
            v_in[k]    = v_reg[k-1];
        end
    end

    // one micro-rotation per stage
    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            if (!z_in[k][CORDIC_W-1]) begin
                x_next[k] = x_in[k] - (y_in[k] >>> k);
                y_next[k] = y_in[k] + (x_in[k] >>> k);
                z_next[k] = z_in[k] - $signed({{(CORDIC_W-STEP_W){1'b0}}, atan_turn(k)});
            end else begin
                x_next[k] = x_in[k] + (y_in[k] >>> k);
                y_next[k] = y_in[k] - (x_in[k] >>> k);
                z_next[k] = z_in[k] + $signed({{(CORDIC_W-STEP_W){1'b0}}, atan_turn(k)});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_in[k];
                end
            end
            if (en[STAGES]) begin
                m_valid_reg <= v_reg[STAGES-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (en[k] && v_in[k]) begin
                x_reg[k]    <= x_next[k];
                y_reg[k]    <= y_next[k];
                z_reg[k]    <= z_next[k];
                addr_reg[k] <= addr_in[k];
                neg_reg[k]  <= neg_in[k];
                oor_reg[k]  <= oor_in[k];
            end
        end
        if (en[STAGES] && v_reg[STAGES-1]) begin
            m_addr_reg <= addr_reg[STAGES-1];
            m_cos_reg  <= to_q15(x_reg[STAGES-1], neg_reg[STAGES-1]);
            m_sin_reg  <= to_q15(y_reg[STAGES-1], neg_reg[STAGES-1]);
            m_oor_reg  <= oor_reg[STAGES-1];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_grid_address = m_addr_reg;
    assign m_cos_value    = m_cos_reg;
    assign m_sin_value    = m_sin_reg;
    assign m_out_of_range = m_oor_reg;

endmodule

/* sim/grid_phase_factor_generator_tb.sv */
`timescale 1ns / 100ps

module grid_phase_factor_generator_tb;
    import gpf_pkg::*;

    localparam int MAX_DIM        = MAX_DIM_DEF;
    localparam int CORDIC_STAGES  = CORDIC_STAGES_DEF;
    localparam int ARC_ENTRIES    = 24;
    localparam longint GAIN_Q30   = 652032874;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEGMENTS       = 4;
    localparam int SEG_WORDS      = 54;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0] grid_address;
        logic [Q15_W-1:0]  cos_value;
        logic [Q15_W-1:0]  sin_value;
        logic              out_of_range;
    } phase_factor_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [OFF_W-1:0]      s_x_offset = '0;
    logic [OFF_W-1:0]      s_y_offset = '0;
    logic [OFF_W-1:0]      s_z_offset = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [ADDR_W-1:0]     m_grid_address;
    logic [Q15_W-1:0]      m_cos_value;
    logic [Q15_W-1:0]      m_sin_value;
    logic                  m_out_of_range;

    // arctangent of 2^-i in 2^-32 turns
    longint arc_turns [ARC_ENTRIES] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
        64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
    };

    logic [SIZE_W-1:0] grid_dim_reg [3] = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
    logic [STEP_W-1:0] turn_step_reg [3] = '{32'd0, 32'd0, 32'd0};

    phase_factor_t pending_factors [$];
    phase_factor_t head_factor;
    int            mismatch_count = 0;
    int            src_idle_pct = 18;
    int            sink_idle_pct = 56;
    int            stall_cycles = 0;

    grid_phase_factor_generator #(
        .MAX_DIM       (MAX_DIM),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_x_offset     (s_x_offset),
        .s_y_offset     (s_y_offset),
        .s_z_offset     (s_z_offset),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_grid_address (m_grid_address),
        .m_cos_value    (m_cos_value),
        .m_sin_value    (m_sin_value),
        .m_out_of_range (m_out_of_range)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [Q15_W-1:0] round_q15(input longint v, input logic negate);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767) begin
            r = 32767;
        end
        if (r < -32768) begin
            r = -32768;
        end
        if (negate) begin
            r = -r;
            if (r > 32767) begin
                r = 32767;
            end
        end
        return Q15_W'(r);
    endfunction

    function automatic phase_factor_t predict_phase_factor(input logic [OFF_W-1:0] ox,
                                                            input logic [OFF_W-1:0] oy,
                                                            input logic [OFF_W-1:0] oz);
        longint        off [3];
        longint        dim [3];
        longint        wrapped [3];
        longint        addr;
        longint        cx;
        longint        cy;
        longint        ang;
        longint        dx;
        longint        dy;
        logic [31:0]   turn;
        logic          folded;
        phase_factor_t r;
        off[0] = longint'($signed(ox));
        off[1] = longint'($signed(oy));
        off[2] = longint'($signed(oz));
        turn = '0;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            dim[i] = (grid_dim_reg[i] > MAX_DIM) ? longint'(MAX_DIM) : longint'(grid_dim_reg[i]);
            wrapped[i] = (off[i] < 0) ? off[i] + dim[i] : off[i];
            if (off[i] > dim[i] / 2 || off[i] < -(dim[i] / 2)) begin
                r.out_of_range = 1'b1;
            end
            turn = turn + 32'(off[i] * longint'(turn_step_reg[i]));
        end
        addr = wrapped[0] * dim[1] * dim[2] + wrapped[1] * dim[2] + wrapped[2];
        r.grid_address = ADDR_W'(addr);

        // quadrants 01 and 10 rotate by half a turn, negate afterwards
        folded = turn[31] ^ turn[30];
        if (folded) begin
            turn = turn + 32'h8000_0000;
        end
        ang = longint'($signed(turn));
        cx = GAIN_Q30;
        cy = 0;
        for (int i = 0; i < CORDIC_STAGES && i < ARC_ENTRIES; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (ang >= 0) begin
                cx = cx - dx;
                cy = cy + dy;
                ang = ang - arc_turns[i];
            end else begin
                cx = cx + dx;
                cy = cy - dy;
                ang = ang + arc_turns[i];
            end
        end
        r.cos_value = round_q15(cx, folded);
        r.sin_value = round_q15(cy, folded);
        return r;
    endfunction

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_factors.size() == 0) begin
                $error("unexpected word: grid_address %0h", m_grid_address);
                mismatch_count++;
            end else begin
                head_factor = pending_factors.pop_front();
                check_field("grid_address", head_factor.grid_address, m_grid_address);
                check_field("cos_value", head_factor.cos_value, m_cos_value);
                check_field("sin_value", head_factor.sin_value, m_sin_value);
                check_field("out_of_range", head_factor.out_of_range, m_out_of_range);
            end
        end
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // leaves cfg_valid high; the caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            REG_X_SIZE:       grid_dim_reg[0] = data[SIZE_W-1:0];
            REG_Y_SIZE:       grid_dim_reg[1] = data[SIZE_W-1:0];
            REG_Z_SIZE:       grid_dim_reg[2] = data[SIZE_W-1:0];
            REG_PHASE_STEP_X: turn_step_reg[0] = data;
            REG_PHASE_STEP_Y: turn_step_reg[1] = data;
            REG_PHASE_STEP_Z: turn_step_reg[2] = data;
            default: ;
        endcase
    endtask

    // upper bits of size writes carry junk
    task automatic apply_config(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                                input logic [SIZE_W-1:0] sz, input logic [STEP_W-1:0] px,
                                input logic [STEP_W-1:0] py, input logic [STEP_W-1:0] pz);
        write_reg(REG_X_SIZE, CFG_DATA_W'({$urandom(), sx}));
        write_reg(REG_Y_SIZE, CFG_DATA_W'({$urandom(), sy}));
        write_reg(REG_Z_SIZE, CFG_DATA_W'({$urandom(), sz}));
        write_reg(REG_PHASE_STEP_X, px);
        write_reg(REG_PHASE_STEP_Y, py);
        write_reg(REG_PHASE_STEP_Z, pz);
        if ($urandom_range(2) == 0) begin
            write_reg(REG_UNMAPPED_LO, $urandom());
            write_reg(REG_UNMAPPED_HI, $urandom());
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_offsets(input int ox, input int oy, input int oz);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_x_offset <= OFF_W'(ox);
        s_y_offset <= OFF_W'(oy);
        s_z_offset <= OFF_W'(oz);
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pending_factors.push_back(predict_phase_factor(OFF_W'(ox), OFF_W'(oy), OFF_W'(oz)));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending_factors.size() != 0);
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(9))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd2;
            3:       return 9'd256;
            4:       return 9'd511;
            5:       return SIZE_W'($urandom_range(257, 511));
            default: return SIZE_W'($urandom_range(3, 255));
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return {2'($urandom_range(3)), 30'd0};
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_offset(input logic [SIZE_W-1:0] size_val);
        int dim;
        int half;
        int roll;
        dim = (size_val > MAX_DIM) ? MAX_DIM : int'(size_val);
        half = dim / 2;
        roll = $urandom_range(99);
        if (roll < 72) begin
            return int'($urandom_range(2 * half)) - half;
        end else if (roll < 84) begin
            case ($urandom_range(3))
                0:       return half;
                1:       return -half;
                2:       return half + 1;
                default: return -dim - 1;
            endcase
        end
        return int'($urandom_range(511));
    endfunction

    task automatic test_reset_defaults();
        send_offsets(0, 0, 0);
        send_offsets(-1, -128, 128);
        send_offsets(255, -256, 7);
        drain_results();
    endtask

    task automatic test_field_extremes();
        apply_config(9'd256, 9'd256, 9'd256, 32'h4000_0000, 32'h0000_0001, 32'h8000_0000);
        send_offsets(0, 0, 0);
        send_offsets(1, 0, 0);
        send_offsets(2, 0, 0);
        send_offsets(3, 0, 0);
        send_offsets(-1, 0, 0);
        send_offsets(128, 128, 128);
        send_offsets(-128, -128, -128);
        send_offsets(129, 0, 0);
        send_offsets(0, -129, 0);
        send_offsets(255, 255, 255);
        send_offsets(-256, -256, -256);
        drain_results();
        apply_config(9'd256, 9'd256, 9'd256, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_offsets(1, 1, 1);
        send_offsets(-1, 0, 0);
        send_offsets(85, -43, 17);
        drain_results();
    endtask

    task automatic test_size_corners();
        // x above the max dimension, y zero, z tiny
        apply_config(9'd511, 9'd0, 9'd3, 32'h1234_5678, 32'h0FED_CBA9, 32'h0300_0000);
        send_offsets(-1, 0, -1);
        send_offsets(-200, 0, -100);
        send_offsets(100, 1, 1);
        send_offsets(0, -1, 0);
        send_offsets(200, 0, 2);
        drain_results();
        apply_config(9'd1, 9'd2, 9'd256, $urandom(), $urandom(), $urandom());
        write_reg(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
        write_reg(REG_UNMAPPED_HI, 32'h0000_0001);
        cfg_valid <= 1'b0;
        send_offsets(0, 0, 0);
        send_offsets(0, -1, -128);
        send_offsets(-1, 1, 255);
        drain_results();
    endtask

    task automatic test_random_sweep(input int src_pct, input int sink_pct, input bit corners);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (corners && seg == 0) begin
                apply_config(9'd1, 9'd1, 9'd1, 32'd0, 32'd0, 32'd0);
            end else if (corners && seg == 1) begin
                apply_config(9'd256, 9'd256, 9'd256,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            end else begin
                apply_config(pick_size(), pick_size(), pick_size(),
                             pick_step(), pick_step(), pick_step());
            end
            for (int n = 0; n < SEG_WORDS; n++) begin
                send_offsets(pick_offset(grid_dim_reg[0]), pick_offset(grid_dim_reg[1]),
                             pick_offset(grid_dim_reg[2]));
            end
            drain_results();
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_field_extremes();
        test_size_corners();
        test_random_sweep(18, 56, 1'b1);
        test_random_sweep(56, 18, 1'b0);
        test_random_sweep(0, 0, 1'b0);
        drain_results();
        repeat (CORDIC_STAGES + 8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/gpf_pkg.sv
hw/rtl/gpf_front.sv
hw/rtl/gpf_queue.sv
hw/rtl/gpf_cordic.sv
hw/rtl/grid_phase_factor_generator.sv
sim/grid_phase_factor_generator_tb.sv
